[rtl/fmprt_pkg.sv]
package fmprt_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = 6;
  localparam int BLK_W   = 32;

  localparam int IN_W    = 136;
  localparam int OUT_W   = 72;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [BLK_W-1:0]  end_block;
    logic [BLK_W-1:0]  start_block;
    logic [LEN_W-1:0]  len;
    logic [ADDR_W-1:0] prefix;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic scan_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_lookup;
    logic hit;
    logic last;
    logic out_free;
  } sts_t;

endpackage

[rtl/fmprt_ram.sv]
module fmprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/fmprt_ctrl.sv]
module fmprt_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  fmprt_pkg::sts_t sts,
  output fmprt_pkg::cmd_t cmd
);
  import fmprt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_EXEC   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    cmd           = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = sts.is_lookup ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_RESULT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.hit || sts.last) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/fmprt_dp.sv]
module fmprt_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [fmprt_pkg::IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [fmprt_pkg::OUT_W-1:0] m_tdata,
  input  fmprt_pkg::cmd_t             cmd,
  output fmprt_pkg::sts_t             sts
);
  import fmprt_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Latched input item.
  logic [1:0]        op_q;
  logic [ADDR_W-1:0] pfx_q;
  logic [LEN_W-1:0]  len_q;
  logic [BLK_W-1:0]  sblk_q;
  logic [BLK_W-1:0]  eblk_q;
  logic [ADDR_W-1:0] key_q;

  logic [ENTRIES-1:0] valid;
  logic [IDX_W-1:0]   scan_idx;
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_pending;

  logic [1:0]       res_status;
  logic [BLK_W-1:0] res_start;
  logic [BLK_W-1:0] res_end;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  entry_t           wr_entry;
  entry_t           rd_entry;
  logic             ram_we;
  logic [ADDR_W-1:0] len_mask;
  logic             key_match;

  // Lowest-numbered empty entry; the downward loop lets the lowest index win.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign wr_entry = '{end_block: eblk_q, start_block: sblk_q, len: len_q, prefix: pfx_q};
  assign ram_we   = cmd.exec && (op_q == OP_ADD) && free_found;

  fmprt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(free_idx),
    .wdata(wr_entry),
    .re   (cmd.scan_step),
    .raddr(scan_idx),
    .rdata(rd_entry)
  );

  // A length of zero matches everything; a length at or above the address
  // width compares the whole address.
  always_comb begin
    if (rd_entry.len == '0) begin
      len_mask = '0;
    end else if (rd_entry.len >= LEN_W'(ADDR_W)) begin
      len_mask = '1;
    end else begin
      len_mask = ~({ADDR_W{1'b1}} >> rd_entry.len[4:0]);
    end
  end

  assign key_match = (((rd_entry.prefix ^ key_q) & len_mask) == '0);

  assign sts.is_lookup = (s_tdata[1:0] == OP_LOOKUP);
  assign sts.hit       = rd_pending && valid[rd_idx] && key_match;
  assign sts.last      = rd_pending && (rd_idx == LAST_IDX);
  assign sts.out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= s_tdata[1:0];
      pfx_q  <= s_tdata[33:2];
      len_q  <= s_tdata[39:34];
      sblk_q <= s_tdata[71:40];
      eblk_q <= s_tdata[103:72];
      key_q  <= s_tdata[135:104];
    end
    rd_idx <= scan_idx;
    if (cmd.exec) begin
      res_start <= '0;
      res_end   <= '0;
      if (op_q == OP_ADD) begin
        res_status <= free_found ? ST_OK : ST_FULL;
      end else begin
        res_status <= ST_OK;
      end
    end else if (cmd.scan_step && sts.hit) begin
      res_status <= ST_OK;
      res_start  <= rd_entry.start_block;
      res_end    <= rd_entry.end_block;
    end else if (cmd.scan_step && sts.last) begin
      res_status <= ST_MISS;
      res_start  <= '0;
      res_end    <= '0;
    end
    if (cmd.out_load) begin
      m_tdata <= {{(OUT_W - 2 - 2 * BLK_W){1'b0}}, res_end, res_start, res_status};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      scan_idx   <= '0;
      rd_pending <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      rd_pending <= cmd.scan_step;
      if (cmd.load) begin
        scan_idx <= '0;
      end else if (cmd.scan_step) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cmd.exec && (op_q == OP_CLEAR)) begin
        valid <= '0;
      end else if (ram_we) begin
        valid[free_idx] <= 1'b1;
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

[rtl/first_match_prefix_range_table.sv]
// First-match prefix range table with sixteen entries.
// The slave channel (s_tvalid, s_tready, s_tdata) takes one command per
// transfer: add an entry, look up an address, or clear the table. The master
// channel (m_tvalid, m_tready, m_tdata) returns exactly one result per command.
// Commands are worked one at a time. An add, a clear or an unused code is
// carried out in a single execute state and its result registered before it
// goes to the output. A lookup reads the entry memory one entry per cycle
// from index zero and stops at the first match or after the last entry; the
// entry memory has a single read port.
// A new command is taken only once the result of the last one has been
// loaded into the output register.
// A finished result waits in an output register, and the next command is
// taken while it does; only when a second result is ready before the first
// has been taken does the block hold it and stop accepting until m_tready.
// Reset empties the table at once (all entries invalid) and drops any result
// not yet taken; the block accepts commands from the first cycle after reset.
module first_match_prefix_range_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // operation[1:0], prefix[33:2], prefix_len[39:34], start_block[71:40],
  // end_block[103:72], key_address[135:104]
  input  logic [fmprt_pkg::IN_W-1:0]  s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // status[1:0], found_start[33:2], found_end[65:34], zero padding above
  output logic [fmprt_pkg::OUT_W-1:0] m_tdata
);
  import fmprt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fmprt_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  fmprt_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .cmd     (cmd),
    .sts     (sts)
  );

endmodule
